@@ src/button_debounce_note_events_unit_assert.svh @@
// Assertion macros shared by the debounce block.
`ifndef BUTTON_DEBOUNCE_NOTE_EVENTS_UNIT_ASSERT_SVH
`define BUTTON_DEBOUNCE_NOTE_EVENTS_UNIT_ASSERT_SVH

// Same-cycle implication, ignored while reset is held.
`define BDNE_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("bdne: implication check failed");

// Next-cycle implication, checked through reset as well.
`define BDNE_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) (ante) |=> (cons)) \
        else $error("bdne: next-cycle check failed");

`endif

@@ src/bdne_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package bdne_pkg;

    // Configuration register indexes
    typedef enum logic [1:0] {
        CFG_DEBOUNCE_LIMIT = 2'd0,
        CFG_NOTE_CHANNEL   = 2'd1,
        CFG_BASE_NOTE      = 2'd2
    } t_cfg_idx;

    localparam logic [7:0] LIMIT_RST   = 8'd3;
    localparam logic [3:0] CHANNEL_RST = 4'd0;
    localparam logic [6:0] BASE_RST    = 7'd64;

    localparam logic [6:0] VEL_ON  = 7'd127;
    localparam logic [6:0] VEL_OFF = 7'd0;

    typedef struct packed {
        logic [7:0] debounce_limit;
        logic [3:0] note_channel;
        logic [6:0] base_note;
    } t_cfg;

    // One raw sample request
    typedef struct packed {
        logic [3:0] button_index;
        logic       raw_pressed;
    } t_req;

    // One note event
    typedef struct packed {
        logic       note_on;
        logic [3:0] channel;
        logic [6:0] note_number;
        logic [6:0] velocity;
        logic [3:0] which_button;
    } t_evt;

endpackage

`default_nettype wire

@@ src/bdne_req_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bdne_req_if;
    logic               valid;
    logic               ready;
    bdne_pkg::t_req     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/bdne_evt_if.sv @@
`timescale 1ns / 1ps
`default_nettype none

interface bdne_evt_if;
    logic               valid;
    logic               ready;
    bdne_pkg::t_evt     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ src/bdne_cfg_regs.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdne_cfg_regs (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_wdata,
    output bdne_pkg::t_cfg      o_cfg
);

    bdne_pkg::t_cfg r_cfg;

    // Register writes; unknown indexes are dropped
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.debounce_limit <= bdne_pkg::LIMIT_RST;
            r_cfg.note_channel   <= bdne_pkg::CHANNEL_RST;
            r_cfg.base_note      <= bdne_pkg::BASE_RST;
        end else if (i_cfg_we) begin
            case (bdne_pkg::t_cfg_idx'(i_cfg_idx))
                bdne_pkg::CFG_DEBOUNCE_LIMIT: r_cfg.debounce_limit <= i_cfg_wdata;
                bdne_pkg::CFG_NOTE_CHANNEL:   r_cfg.note_channel   <= i_cfg_wdata[3:0];
                bdne_pkg::CFG_BASE_NOTE:      r_cfg.base_note      <= i_cfg_wdata[6:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

`default_nettype wire

@@ src/bdne_core.sv @@
`timescale 1ns / 1ps
`default_nettype none

module bdne_core #(
    parameter int NUM_BUTTONS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    input  wire logic           i_step,
    input  wire bdne_pkg::t_req i_req,
    input  wire bdne_pkg::t_cfg i_cfg,
    output logic                o_hit,
    output bdne_pkg::t_evt      o_evt
);

    // Only the first sixteen buttons are reachable by a 4-bit index
    localparam int DEPTH = (NUM_BUTTONS < 16) ? NUM_BUTTONS : 16;
    localparam int IW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam logic [8:0] NB = 9'(NUM_BUTTONS);

    logic [7:0]    r_integ [DEPTH];
    logic [DEPTH-1:0] r_state;

    logic [IW-1:0] addr;
    logic          in_range;
    logic [7:0]    cnt;
    logic [7:0]    n_cnt;
    logic          at_limit;
    logic          at_zero;
    logic          target;
    logic          emit;

    assign in_range = ({5'd0, i_req.button_index} < NB);
    assign addr     = i_req.button_index[IW-1:0];

    // Saturating integrator update and state compare
    always_comb begin
        cnt   = in_range ? r_integ[addr] : 8'd0;
        n_cnt = cnt;
        if (i_req.raw_pressed) begin
            if (cnt < i_cfg.debounce_limit) n_cnt = cnt + 8'd1;
        end else begin
            if (cnt != 8'd0) n_cnt = cnt - 8'd1;
        end
        at_limit = (n_cnt == i_cfg.debounce_limit);
        at_zero  = (n_cnt == 8'd0);
        target   = at_limit;
        emit     = in_range && (at_limit || at_zero) && (r_state[addr] != target);
    end

    // Per-button stores
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < DEPTH; k++) r_integ[k] <= 8'd0;
            r_state <= '0;
        end else if (i_step && in_range) begin
            r_integ[addr] <= n_cnt;
            if (emit) r_state[addr] <= target;
        end
    end

    // Event fields
    always_comb begin
        o_hit              = emit;
        o_evt.note_on      = target;
        o_evt.channel      = i_cfg.note_channel;
        o_evt.note_number  = 7'(i_cfg.base_note + {3'd0, i_req.button_index});
        o_evt.velocity     = target ? bdne_pkg::VEL_ON : bdne_pkg::VEL_OFF;
        o_evt.which_button = i_req.button_index;
    end

endmodule

`default_nettype wire

@@ src/button_debounce_note_events_unit.sv @@
// Button debounce with note events.
// i_req carries one raw sample request per transfer: a button index and its
// pressed bit. o_evt carries note events: note on (velocity 127) when a
// button's integrator reaches the debounce limit, note off (velocity 0) when
// it falls back to zero, on the configured channel at base note + index.
// A sample gives zero or one event; samples for indexes at or beyond
// NUM_BUTTONS are dropped without effect.
// Configuration goes through i_cfg_we / i_cfg_idx / i_cfg_wdata; the user must write
// it only while the block is idle, as the block itself does not enforce this.
// An event passes through the input register and then the result register before
// it is presented on o_evt. Throughput: one sample per cycle while no held event
// is stalled on o_evt; the per-button counter read-modify-write is done as each sample steps.
// Reset (synchronous, active low) clears all integrators and debounced
// states to released and restores limit 3, channel 0, base note 64.
// When o_evt stalls with an event pending, the pipeline holds and i_req
// drops ready once the input register is also full.
`timescale 1ns / 1ps
`default_nettype none

`include "button_debounce_note_events_unit_assert.svh"

module button_debounce_note_events_unit #(
    parameter int NUM_BUTTONS = 16
) (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    bdne_req_if.sink            i_req,
    bdne_evt_if.source          o_evt,
    input  wire logic           i_cfg_we,
    input  wire logic [1:0]     i_cfg_idx,
    input  wire logic [7:0]     i_cfg_wdata
);

    bdne_pkg::t_cfg cfg;
    logic           r_in_valid;
    bdne_pkg::t_req r_in;
    logic           r_out_valid;
    bdne_pkg::t_evt r_out;
    logic           advance;
    logic           step;
    logic           hit;
    bdne_pkg::t_evt evt;
    logic [6:0]     vel_want;

    bdne_cfg_regs u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_idx   (i_cfg_idx),
        .i_cfg_wdata (i_cfg_wdata),
        .o_cfg       (cfg)
    );

    bdne_core #(.NUM_BUTTONS(NUM_BUTTONS)) u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_step  (step),
        .i_req   (r_in),
        .i_cfg   (cfg),
        .o_hit   (hit),
        .o_evt   (evt)
    );

    // Pipeline moves when the result register is free or being drained
    assign advance     = !r_out_valid || o_evt.ready;
    assign step        = r_in_valid && advance;
    assign i_req.ready = !r_in_valid || advance;

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_req.ready) begin
            r_in_valid <= i_req.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_req.valid && i_req.ready) r_in <= i_req.data;
    end

    // Result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= step && hit;
        end
    end

    always_ff @(posedge i_clk) begin
        if (step && hit) r_out <= evt;
    end

    assign o_evt.valid = r_out_valid;
    assign o_evt.data  = r_out;

    // Velocity that the held event must carry
    assign vel_want = r_out.note_on ? bdne_pkg::VEL_ON : bdne_pkg::VEL_OFF;

    // Checks
    `BDNE_ASSERT_IMPL(a_stall_cause, !i_req.ready, r_in_valid && r_out_valid && !o_evt.ready)
    `BDNE_ASSERT_IMPL(a_vel_match, r_out_valid, r_out.velocity == vel_want)
    `BDNE_ASSERT_NEXT(a_rst_empty, !i_rst_n, !r_in_valid && !r_out_valid)

endmodule

`default_nettype wire
